[rtl/dist_pkg.sv]
// Shared constants, codes and request types of the dense id slot table.
package dist_pkg;

    localparam int ID_W     = 16;
    localparam int ID_SPACE = 1 << ID_W;
    localparam int SLOTS    = 1024;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int HANDLE_W = 32;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;

    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FIND  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIRST = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEXT  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUP  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

    // One slot entry: occupancy flag and the stored handle.
    typedef struct packed {
        logic                used;
        logic [HANDLE_W-1:0] handle;
    } slot_word_t;

    // Access to the id map and its reverse (slot to id) map.
    typedef struct packed {
        logic              map_rd;
        logic              map_wr;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] map_wdata;
        logic              rev_rd;
        logic              rev_wr;
        logic [SLOT_W-1:0] rev_addr;
    } map_req_t;

    // Access to the slot store.
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [SLOT_W-1:0] addr;
        slot_word_t        wdata;
    } slot_req_t;

endpackage

[rtl/dist_if.sv]
// Request and response channel interfaces of the dense id slot table.
interface dist_req_if;
    import dist_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     field_id;
    logic [HANDLE_W-1:0] handle_in;

    modport source (output valid, cmd, field_id, handle_in, input ready);
    modport sink   (input valid, cmd, field_id, handle_in, output ready);
endinterface

interface dist_rsp_if;
    import dist_pkg::*;

    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] handle_out;
    logic [SLOT_W-1:0]   slot;
    logic                has_more;

    modport source (output valid, status, handle_out, slot, has_more, input ready);
    modport sink   (input valid, status, handle_out, slot, has_more, output ready);
endinterface

[rtl/dist_id_map.sv]
// Id-to-slot map and slot-to-id reverse map, both single-port memories.
module dist_id_map (
    input  logic                     clk,
    input  dist_pkg::map_req_t       map_req,
    output logic [dist_pkg::SLOT_W-1:0] map_rdata,
    output logic [dist_pkg::ID_W-1:0]   rev_rdata
);
    import dist_pkg::*;

    bit   [SLOT_W-1:0] map_mem [ID_SPACE];
    logic [ID_W-1:0]   rev_mem [SLOTS];
    logic [SLOT_W-1:0] map_rdata_reg;
    logic [ID_W-1:0]   rev_rdata_reg;

    // An entry is trusted only when its slot is issued and points back at the id,
    // so neither memory needs clearing.
    always_ff @(posedge clk)
    begin
        if (map_req.map_wr)
        begin
            map_mem[map_req.id] <= map_req.map_wdata;
        end
        if (map_req.map_rd)
        begin
            map_rdata_reg <= map_mem[map_req.id];
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_req.rev_wr)
        begin
            rev_mem[map_req.rev_addr] <= map_req.id;
        end
        if (map_req.rev_rd)
        begin
            rev_rdata_reg <= rev_mem[map_req.rev_addr];
        end
    end

    assign map_rdata = map_rdata_reg;
    assign rev_rdata = rev_rdata_reg;

endmodule

[rtl/dist_slot_store.sv]
// Slot store: occupancy flag and handle of every dense slot.
module dist_slot_store (
    input  logic                  clk,
    input  dist_pkg::slot_req_t   slot_req,
    output dist_pkg::slot_word_t  slot_rdata
);
    import dist_pkg::*;

    slot_word_t slot_mem [SLOTS];
    slot_word_t slot_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (slot_req.wr)
        begin
            slot_mem[slot_req.addr] <= slot_req.wdata;
        end
        if (slot_req.rd)
        begin
            slot_rdata_reg <= slot_mem[slot_req.addr];
        end
    end

    assign slot_rdata = slot_rdata_reg;

endmodule

[rtl/dense_id_slot_table.sv]
// Top level of the dense id slot table: command sequencer and result register.
//
// Maps sparse 16-bit ids to dense slots handed out in first-seen order; add and
// find give an unseen id the next free slot, add stores a handle, find returns
// it, clear empties every slot but keeps the id map and slot counter, and
// first/next walk the occupied slots in ascending order reporting slot, handle
// and whether another occupied slot follows. After reset the block runs a
// clearing pass over the whole slot store with req.ready low. One command is
// worked at a time by a small sequencer around one slot index counter and the
// single-port memories: add and find go through id map read, reverse map and
// slot read, decide and result load before the next accept; clear sweeps the
// slot store at one slot a cycle; first and next examine the slots one at a
// time, a read state and a check state per slot, from the walk start until an
// occupied slot after the reported one is found or the end is reached. A
// finished beat waits in the output register while the next command is
// already accepted.
module dense_id_slot_table (
    input  logic           clk,
    input  logic           rst_n,
    dist_req_if.sink       req,
    dist_rsp_if.source     rsp
);
    import dist_pkg::*;

    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_LOOK     = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_CLEAR    = 3'd4;
    localparam logic [2:0] S_SCAN_RD  = 3'd5;
    localparam logic [2:0] S_SCAN_CHK = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    localparam logic [CNT_W-1:0] SLOT_END  = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] SLOT_LAST = CNT_W'(SLOTS - 1);

    // Control state
    logic [2:0]       state_reg,    state_next;
    logic [CNT_W-1:0] idx_reg,      idx_next;
    logic [CNT_W-1:0] issued_reg,   issued_next;
    logic [CNT_W-1:0] walk_pos_reg, walk_pos_next;
    logic             found_reg,    found_next;
    logic             out_valid_reg, out_valid_next;

    // Payload held per command
    logic [CMD_W-1:0]    cmd_reg,  cmd_next;
    logic [ID_W-1:0]     id_reg,   id_next;
    logic [HANDLE_W-1:0] hdl_reg,  hdl_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SLOT_W-1:0]   fslot_reg, fslot_next;
    logic [HANDLE_W-1:0] fhdl_reg,  fhdl_next;

    // Pending result and output register
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic [SLOT_W-1:0]   res_slot_reg,   res_slot_next;
    logic                res_more_reg,   res_more_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;
    logic [HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic [SLOT_W-1:0]   out_slot_reg,   out_slot_next;
    logic                out_more_reg,   out_more_next;

    map_req_t          map_req;
    slot_req_t         slot_req;
    logic [SLOT_W-1:0] map_rdata;
    logic [ID_W-1:0]   rev_rdata;
    slot_word_t        slot_rdata;

    logic              map_hit;
    logic [SLOT_W-1:0] sel_slot;
    logic              sel_used;

    dist_id_map u_id_map (
        .clk       (clk),
        .map_req   (map_req),
        .map_rdata (map_rdata),
        .rev_rdata (rev_rdata)
    );

    dist_slot_store u_slot_store (
        .clk        (clk),
        .slot_req   (slot_req),
        .slot_rdata (slot_rdata)
    );

    // The map entry is real only if its slot is already issued and the
    // reverse map names this same id.
    assign map_hit  = ({1'b0, slot_reg} < issued_reg) && (rev_rdata == id_reg);
    assign sel_slot = map_hit ? slot_reg : issued_reg[SLOT_W-1:0];
    assign sel_used = map_hit && slot_rdata.used;

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issued_next     = issued_reg;
        walk_pos_next   = walk_pos_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        hdl_next        = hdl_reg;
        slot_next       = slot_reg;
        fslot_next      = fslot_reg;
        fhdl_next       = fhdl_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_slot_next   = res_slot_reg;
        res_more_next   = res_more_reg;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_slot_next   = out_slot_reg;
        out_more_next   = out_more_reg;
        map_req         = '0;
        slot_req        = '0;

        // Drop the output beat once taken.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                // Sweep the slot store, one slot a cycle, marking every slot empty.
                slot_req.wr   = 1'b1;
                slot_req.addr = idx_reg[SLOT_W-1:0];
                if (idx_reg == SLOT_LAST)
                begin
                    idx_next = '0;
                    if (state_reg == S_INIT)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_status_next = ST_OK;
                        res_handle_next = '0;
                        res_slot_next   = '0;
                        res_more_next   = 1'b0;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    id_next    = req.field_id;
                    hdl_next   = req.handle_in;
                    found_next = 1'b0;
                    case (req.cmd)
                        CMD_ADD, CMD_FIND:
                        begin
                            map_req.map_rd = 1'b1;
                            map_req.id     = req.field_id;
                            state_next     = S_LOOK;
                        end
                        CMD_CLEAR:
                        begin
                            idx_next   = '0;
                            state_next = S_CLEAR;
                        end
                        CMD_FIRST:
                        begin
                            idx_next   = '0;
                            state_next = S_SCAN_RD;
                        end
                        CMD_NEXT:
                        begin
                            idx_next   = walk_pos_reg;
                            state_next = S_SCAN_RD;
                        end
                        default:
                        begin
                            res_status_next = ST_MISS;
                            res_handle_next = '0;
                            res_slot_next   = '0;
                            res_more_next   = 1'b0;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                // Check the candidate slot from both sides.
                slot_next        = map_rdata;
                map_req.rev_rd   = 1'b1;
                map_req.rev_addr = map_rdata;
                slot_req.rd      = 1'b1;
                slot_req.addr    = map_rdata;
                state_next       = S_DECIDE;
            end

            S_DECIDE:
            begin
                res_handle_next = '0;
                res_more_next   = 1'b0;
                res_slot_next   = sel_slot;
                state_next      = S_DONE;
                if (!map_hit && (issued_reg == SLOT_END))
                begin
                    res_status_next = ST_FULL;
                    res_slot_next   = '0;
                end
                else
                begin
                    if (!map_hit)
                    begin
                        // Issue the next slot to this id.
                        map_req.map_wr    = 1'b1;
                        map_req.id        = id_reg;
                        map_req.map_wdata = sel_slot;
                        map_req.rev_wr    = 1'b1;
                        map_req.rev_addr  = sel_slot;
                        issued_next       = issued_reg + CNT_W'(1);
                    end
                    if (cmd_reg == CMD_ADD)
                    begin
                        if (sel_used)
                        begin
                            res_status_next = ST_DUP;
                        end
                        else
                        begin
                            slot_req.wr            = 1'b1;
                            slot_req.addr          = sel_slot;
                            slot_req.wdata.used    = 1'b1;
                            slot_req.wdata.handle  = hdl_reg;
                            res_status_next        = ST_OK;
                        end
                    end
                    else if (sel_used)
                    begin
                        res_status_next = ST_OK;
                        res_handle_next = slot_rdata.handle;
                    end
                    else
                    begin
                        res_status_next = ST_MISS;
                    end
                end
            end

            S_SCAN_RD:
            begin
                if (idx_reg == SLOT_END)
                begin
                    // End of table: report the slot found, if any.
                    res_more_next = 1'b0;
                    state_next    = S_DONE;
                    if (found_reg)
                    begin
                        res_status_next = ST_OK;
                        res_handle_next = fhdl_reg;
                        res_slot_next   = fslot_reg;
                        walk_pos_next   = CNT_W'(fslot_reg) + CNT_W'(1);
                    end
                    else
                    begin
                        res_status_next = ST_MISS;
                        res_handle_next = '0;
                        res_slot_next   = '0;
                        if (cmd_reg == CMD_FIRST)
                        begin
                            walk_pos_next = '0;
                        end
                    end
                end
                else
                begin
                    slot_req.rd   = 1'b1;
                    slot_req.addr = idx_reg[SLOT_W-1:0];
                    state_next    = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (slot_rdata.used && found_reg)
                begin
                    // A second occupied slot: the reported one has a successor.
                    res_status_next = ST_OK;
                    res_handle_next = fhdl_reg;
                    res_slot_next   = fslot_reg;
                    res_more_next   = 1'b1;
                    walk_pos_next   = CNT_W'(fslot_reg) + CNT_W'(1);
                    state_next      = S_DONE;
                end
                else
                begin
                    if (slot_rdata.used)
                    begin
                        found_next = 1'b1;
                        fslot_next = idx_reg[SLOT_W-1:0];
                        fhdl_next  = slot_rdata.handle;
                    end
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_DONE:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    out_slot_next   = res_slot_reg;
                    out_more_next   = res_more_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            idx_reg       <= '0;
            issued_reg    <= '0;
            walk_pos_reg  <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            issued_reg    <= issued_next;
            walk_pos_reg  <= walk_pos_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        hdl_reg        <= hdl_next;
        slot_reg       <= slot_next;
        fslot_reg      <= fslot_next;
        fhdl_reg       <= fhdl_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_slot_reg   <= res_slot_next;
        res_more_reg   <= res_more_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_slot_reg   <= out_slot_next;
        out_more_reg   <= out_more_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.handle_out = out_handle_reg;
    assign rsp.slot       = out_slot_reg;
    assign rsp.has_more   = out_more_reg;

endmodule

[test/dense_id_slot_table_test.sv]
// Self-checking testbench of the dense id slot table: random commands against a table model.
module dense_id_slot_table_test;
    import dist_pkg::*;

    // Command codes the block does not define; it answers them with a plain miss.
    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 7;
    localparam int TOTAL_CMDS = 2020;
    // Wait longer than the worst walk for stray beats at the end.
    localparam int SETTLE_CYCLES = 2 * SLOTS + 16;
    // Every command at its slowest walk plus the longest gap and stall, taken several times.
    localparam longint CYCLE_LIMIT = 15_000_000;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
    } cmd_beat_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [HANDLE_W-1:0] handle_out;
        logic [SLOT_W-1:0]   slot;
        logic                has_more;
    } reply_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    dist_req_if req_ch ();
    dist_rsp_if rsp_ch ();

    dense_id_slot_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Table model: id map, slot store, occupancy bits, slot counter and
    // walk cursor, updated once per accepted command beat.
    // ------------------------------------------------------------------
    bit [CNT_W-1:0]      id_map [ID_SPACE];     // 0 = no slot yet, else slot + 1
    logic [HANDLE_W-1:0] slot_handle [SLOTS];
    bit                  slot_used [SLOTS];
    int                  slots_issued = 0;
    int                  walk_pos = 0;

    cmd_beat_t   cmd_backlog [$];
    reply_beat_t lookup_answers [$];

    // Stimulus bookkeeping: which ids were ever named, and those that got a slot.
    bit               id_seen [ID_SPACE];
    logic [ID_W-1:0]  granted_ids [$];
    int               ids_granted = 0;

    int     mismatches = 0;
    longint cycle_count = 0;

    // Give the id its slot, handing out the next one if the id is new.
    // Returns 0 when the id is new and every slot is already issued.
    function automatic bit claim_slot(input logic [ID_W-1:0] id, output logic [SLOT_W-1:0] s);
        s = '0;
        if (id_map[id] != 0)
        begin
            s = SLOT_W'(id_map[id] - 1);
            return 1'b1;
        end
        if (slots_issued >= SLOTS)
            return 1'b0;
        s = SLOT_W'(slots_issued);
        slots_issued++;
        id_map[id] = CNT_W'(slots_issued);
        return 1'b1;
    endfunction

    function automatic int first_used(int start);
        for (int i = start; i < SLOTS; i++)
            if (slot_used[i])
                return i;
        return SLOTS;
    endfunction

    // First reports from slot 0 and rewinds the cursor on an empty table;
    // next at the end leaves the cursor where it is.
    function automatic reply_beat_t walk_slots(int start, bit from_top);
        reply_beat_t r;
        int hit;
        r = '0;
        hit = first_used(start);
        if (hit >= SLOTS)
        begin
            if (from_top)
                walk_pos = 0;
            r.status = ST_MISS;
            return r;
        end
        walk_pos = hit + 1;
        r.status = ST_OK;
        r.handle_out = slot_handle[hit];
        r.slot = SLOT_W'(hit);
        r.has_more = (first_used(hit + 1) < SLOTS);
        return r;
    endfunction

    function automatic reply_beat_t apply_table_cmd(cmd_beat_t c);
        reply_beat_t r;
        logic [SLOT_W-1:0] s;
        r = '0;
        r.status = ST_MISS;
        case (c.cmd)
            CMD_ADD:
            begin
                if (!claim_slot(c.id, s))
                    r.status = ST_FULL;
                else
                begin
                    r.slot = s;
                    if (slot_used[s])
                        r.status = ST_DUP;
                    else
                    begin
                        slot_handle[s] = c.handle;
                        slot_used[s] = 1'b1;
                        r.status = ST_OK;
                    end
                end
            end
            CMD_FIND:
            begin
                if (!claim_slot(c.id, s))
                    r.status = ST_FULL;
                else
                begin
                    r.slot = s;
                    if (slot_used[s])
                    begin
                        r.status = ST_OK;
                        r.handle_out = slot_handle[s];
                    end
                end
            end
            CMD_CLEAR:
            begin
                // Empty the slots; the id map and the counter stay.
                slot_used = '{default: 1'b0};
                r.status = ST_OK;
            end
            CMD_FIRST:
                r = walk_slots(0, 1'b1);
            CMD_NEXT:
                r = walk_slots(walk_pos, 1'b0);
            default:
                ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly no idling, some short gaps, a few long ones, and now and then a
    // calm stretch with no idling at all.
    function automatic int idle_cycles(inout int calm_left);
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 62)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] id;
        id = ID_W'($urandom);
        while (id_seen[id])
            id = ID_W'($urandom);
        return id;
    endfunction

    // While the table fills, name mostly new ids; once full, mostly ids that
    // own a slot so finds hit and adds come back as duplicates.
    function automatic logic [ID_W-1:0] pick_id(bit filling);
        int fresh_pct;
        fresh_pct = filling ? 92 : 6;
        if (granted_ids.size() == 0 || $urandom_range(0, 99) < fresh_pct)
            return fresh_id();
        return granted_ids[$urandom_range(0, granted_ids.size() - 1)];
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        return HANDLE_W'($urandom);
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [HANDLE_W-1:0] handle);
        cmd_beat_t c;
        c.cmd = cmd;
        c.id = id;
        c.handle = handle;
        // Track ids in the order the block will see them, so the generator
        // knows which ones own a slot.
        if ((cmd == CMD_ADD || cmd == CMD_FIND) && !id_seen[id])
        begin
            id_seen[id] = 1'b1;
            if (ids_granted < SLOTS)
            begin
                granted_ids.push_back(id);
                ids_granted++;
            end
        end
        cmd_backlog.push_back(c);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present the backlog one beat at a time, hold a beat until the
    // block takes it, and predict the reply at the accepting edge.
    // ------------------------------------------------------------------
    cmd_beat_t driven_cmd;
    int        send_gap = 0;
    int        send_calm = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.cmd       <= CMD_ADD;
            req_ch.field_id  <= '0;
            req_ch.handle_in <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                lookup_answers.push_back(apply_table_cmd(driven_cmd));
            // Hold a beat the block has not taken yet.
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0 || cmd_backlog.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    driven_cmd = cmd_backlog.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.cmd       <= driven_cmd.cmd;
                    req_ch.field_id  <= driven_cmd.id;
                    req_ch.handle_in <= driven_cmd.handle;
                    send_gap = idle_cycles(send_calm);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the reply side at random and compare every reply beat
    // with the oldest prediction.
    // ------------------------------------------------------------------
    reply_beat_t want_reply;
    int          stall_left = 0;
    int          stall_calm = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (lookup_answers.size() == 0)
                begin
                    $error("reply beat with nothing expected: status %0d slot %0d",
                           rsp_ch.status, rsp_ch.slot);
                    mismatches++;
                end
                else
                begin
                    want_reply = lookup_answers.pop_front();
                    check_field("status", want_reply.status, rsp_ch.status);
                    check_field("handle_out", want_reply.handle_out, rsp_ch.handle_out);
                    check_field("slot", want_reply.slot, rsp_ch.slot);
                    check_field("has_more", want_reply.has_more, rsp_ch.has_more);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall_left = idle_cycles(stall_calm);
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int  roll;
        int  pick;
        bit  filling;
        logic [CMD_W-1:0] odd_cmd;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ADD;
        req_ch.field_id = '0;
        req_ch.handle_in = '0;
        rsp_ch.ready = 1'b0;

        // Directed: walks on an empty table, allocation by find, duplicate
        // add, extreme ids and handles, a full walk past the end, clear
        // keeping the id map, and the undefined command codes.
        queue_cmd(CMD_FIRST, '0, '0);
        queue_cmd(CMD_NEXT, '0, '0);
        queue_cmd(CMD_FIND, 16'hFFFF, '1);
        queue_cmd(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF);
        queue_cmd(CMD_ADD, 16'hFFFF, 32'h0000_0000);
        queue_cmd(CMD_FIND, 16'hFFFF, '0);
        queue_cmd(CMD_ADD, 16'h0000, 32'h0000_0000);
        queue_cmd(CMD_ADD, 16'h8000, 32'hA5A5_A5A5);
        queue_cmd(CMD_ADD, 16'h1234, 32'h5A5A_5A5A);
        queue_cmd(CMD_FIRST, '0, '0);
        queue_cmd(CMD_NEXT, '0, '0);
        queue_cmd(CMD_NEXT, '0, '0);
        queue_cmd(CMD_NEXT, '0, '0);
        queue_cmd(CMD_NEXT, '1, '1);
        queue_cmd(CMD_CLEAR, '1, '1);
        queue_cmd(CMD_FIND, 16'h0000, '0);
        queue_cmd(CMD_FIRST, '0, '0);
        queue_cmd(CMD_ADD, 16'h8000, 32'h8000_0001);
        queue_cmd(CMD_FIRST, '0, '0);
        queue_cmd(CMD_NEXT, '0, '0);
        queue_cmd(CMD_RSVD_5, 16'h1234, 32'h1234_5678);
        queue_cmd(CMD_RSVD_6, '1, '1);
        queue_cmd(CMD_RSVD_7, '0, '0);

        // Random: fill the table with mostly new ids, then work it hard once
        // the counter is exhausted. Walks come as a first followed by nexts.
        while (cmd_backlog.size() < TOTAL_CMDS)
        begin
            filling = (ids_granted < SLOTS);
            roll = $urandom_range(0, 99);
            if (roll < 52)
                queue_cmd(CMD_ADD, pick_id(filling), pick_handle());
            else if (roll < 78)
                queue_cmd(CMD_FIND, pick_id(filling), pick_handle());
            else if (roll < 80)
                queue_cmd(CMD_CLEAR, fresh_id(), pick_handle());
            else if (roll < 82)
            begin
                pick = $urandom_range(0, 2);
                odd_cmd = (pick == 0) ? CMD_RSVD_5 : (pick == 1) ? CMD_RSVD_6 : CMD_RSVD_7;
                queue_cmd(odd_cmd, ID_W'($urandom), pick_handle());
            end
            else if (roll < 85)
                queue_cmd(CMD_FIRST, ID_W'($urandom), pick_handle());
            else if (roll < 89)
                queue_cmd(CMD_NEXT, ID_W'($urandom), pick_handle());
            else if (roll < (filling ? 92 : 100))
            begin
                queue_cmd(CMD_FIRST, ID_W'($urandom), pick_handle());
                repeat ($urandom_range(1, 6))
                    queue_cmd(CMD_NEXT, ID_W'($urandom), pick_handle());
            end
            else
                queue_cmd(CMD_ADD, pick_id(filling), pick_handle());
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every beat sent and every reply in, then watch for strays.
        while (cmd_backlog.size() != 0 || req_ch.valid || lookup_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
